>>> sv/pizhst_pkg.sv
// Shared types and constants for the point-in-zone half-space test block.
// Used by pizhst_mac and point_in_zone_halfspace_test_top; no dependencies.
`default_nettype none

package pizhst_pkg;

    localparam int MAX_NORMALS = 32;
    localparam int COORD_BITS  = 18;

    // configuration register widths and reset values
    localparam int R2_W  = 36;
    localparam int TOL_W = 16;
    localparam logic [R2_W-1:0]  R2_RESET  = {R2_W{1'b1}};
    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(7);

    // configuration port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = R2_W;
    localparam logic [CFG_IDX_W-1:0] REG_SPHERE_R2 = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = CFG_IDX_W'(1);

    // Q1.16 scale factors: 1.0 and 0.5
    localparam int SC_W = TOL_W + 1;
    localparam logic [SC_W-1:0] SCALE_ONE  = SC_W'(65536);
    localparam logic [SC_W-1:0] SCALE_HALF = SC_W'(32768);
    localparam int FRAC_SHIFT = 16;

    // table sizing
    localparam int IDX_W = $clog2(MAX_NORMALS);
    localparam int CNT_W = $clog2(MAX_NORMALS + 1);

    // arithmetic widths
    localparam int LEN_W  = 2 * COORD_BITS;          // squared length / |dot|
    localparam int ACC_W  = 2 * COORD_BITS + 1;      // signed dot accumulator
    localparam int MA_W   = ((LEN_W > R2_W) ? LEN_W : R2_W) + 1;
    localparam int MB_W   = (COORD_BITS > SC_W + 1) ? COORD_BITS : SC_W + 1;
    localparam int PROD_W = MA_W + MB_W;

    // stream widths
    localparam int TDATA_IN_W  = ((3 * COORD_BITS + 7) / 8) * 8;
    localparam int TUSER_IN_W  = 2;
    localparam int TDATA_OUT_W = 8;

    // per-pass step counter: three coordinate products, one scaled bound,
    // then the compare
    localparam int PH_W = 3;
    localparam logic [PH_W-1:0] PH_X     = PH_W'(0);
    localparam logic [PH_W-1:0] PH_Y     = PH_W'(1);
    localparam logic [PH_W-1:0] PH_Z     = PH_W'(2);
    localparam logic [PH_W-1:0] PH_SCALE = PH_W'(3);
    localparam logic [PH_W-1:0] PH_CMP   = PH_W'(4);

    typedef enum logic [1:0] {
        REQ_CLEAR = 2'd0,
        REQ_LOAD  = 2'd1,
        REQ_QUERY = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        CAUSE_NONE   = 2'd0,
        CAUSE_SPHERE = 2'd1,
        CAUSE_PLANE  = 2'd2
    } t_cause;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] z;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] x;
    } t_vec;

    typedef struct packed {
        logic [LEN_W-1:0] len_sq;
        t_vec             n;
    } t_entry;

    typedef struct packed {
        logic acc_clr;
        logic acc_add;
    } t_mac_ctrl;

endpackage

`default_nettype wire

>>> sv/pizhst_mac.sv
// Shared multiply-accumulate unit with the scaled magnitude compare.
// Depends on pizhst_pkg for widths and the control struct.
`default_nettype none

module pizhst_mac
    import pizhst_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire t_mac_ctrl                i_ctrl,
    input  wire logic signed [MA_W-1:0]   i_opa,
    input  wire logic signed [MB_W-1:0]   i_opb,
    output logic             [LEN_W-1:0]  o_len,
    output logic                          o_gt
);

    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  n_acc;
    logic        [ACC_W-1:0]  acc_abs;
    logic        [PROD_W-1:0] lhs;

    always_comb begin
        n_acc = r_acc;
        if (i_ctrl.acc_clr) begin
            n_acc = '0;
        end else if (i_ctrl.acc_add) begin
            n_acc = r_acc + r_prod[ACC_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_opa * i_opb;
        r_acc  <= n_acc;
    end

    // |acc| * 1.0 against the scaled bound left in the product register
    assign acc_abs = r_acc[ACC_W-1] ? ACC_W'(-r_acc) : ACC_W'(r_acc);
    assign lhs     = PROD_W'(acc_abs[LEN_W-1:0]) << FRAC_SHIFT;
    assign o_gt    = lhs > $unsigned(r_prod);
    assign o_len   = r_acc[LEN_W-1:0];

endmodule

`default_nettype wire

>>> sv/point_in_zone_halfspace_test_top.sv
// Point-in-zone half-space test: sequencer, normal table and output register.
// Depends on pizhst_pkg and pizhst_mac.
//
// Requests arrive on the s_axis channel: tuser carries the request kind
// (clear, load normal, query point) and tdata the x, y, z coordinates.
// Only a query produces a response on m_axis: inside flag, reject cause and
// the sticky table overflow flag. Configuration (sphere radius squared and
// tolerance) is written through i_cfg_we / i_cfg_idx / i_cfg_wdata; the user
// must write it only while the block is idle; the block does not enforce this.
// All arithmetic runs through one multiply-accumulate unit; each vector pass
// runs three coordinate products, one scaled bound and one compare in turn.
// A clear or a dropped load (table full) is handled in idle, a stored load
// runs one pass and then writes the table, and a query runs the sphere pass,
// then one pass per normal until a plane rejects, delivers from the result
// state and goes back to idle. s_axis_tready is high only while the sequencer
// is idle. The response sits in an output register, so a stalled receiver
// does not block the next request; a second response waits in the sequencer
// until the first is taken. Reset empties the table, clears the overflow flag
// and restores the register defaults; there is no clearing pass.
`default_nettype none

module point_in_zone_halfspace_test_top
    import pizhst_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // configuration write port
    input  wire logic                    i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0]   i_cfg_wdata,
    // request stream
    input  wire logic                    s_axis_tvalid,
    output logic                         s_axis_tready,
    input  wire logic [TDATA_IN_W-1:0]   s_axis_tdata,  // coord_x, coord_y, coord_z, pad
    input  wire logic [TUSER_IN_W-1:0]   s_axis_tuser,  // req_type
    // response stream
    output logic                         m_axis_tvalid,
    input  wire logic                    m_axis_tready,
    output logic [TDATA_OUT_W-1:0]       m_axis_tdata   // is_inside, reject_cause,
                                                        // table_overflow, pad
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_LOAD   = 5'b00010,
        ST_SPHERE = 5'b00100,
        ST_PLANE  = 5'b01000,
        ST_RESULT = 5'b10000
    } t_state;

    t_state             r_state, n_state;
    logic [PH_W-1:0]    r_phase, n_phase;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_ovf, n_ovf;
    t_cause             r_cause, n_cause;
    logic [R2_W-1:0]    r_r2;
    logic [TOL_W-1:0]   r_tol;
    t_vec               r_q;
    logic               r_out_valid;
    logic [TDATA_OUT_W-1:0] r_out_data;

    t_entry             mem [MAX_NORMALS];
    t_entry             r_rd_data;
    logic               mem_we;

    logic               accept;
    logic               out_load;
    t_req               req;
    t_vec               vec;
    logic [SC_W-1:0]    one_eps, half_eps;
    t_mac_ctrl          mac_ctrl;
    logic signed [MA_W-1:0] opa;
    logic signed [MB_W-1:0] opb;
    logic [LEN_W-1:0]   mac_len;
    logic               mac_gt;
    logic               last_normal;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign req           = t_req'(s_axis_tuser);
    assign one_eps       = SCALE_ONE + SC_W'(r_tol);
    assign half_eps      = SCALE_HALF + SC_W'(r_tol);
    assign last_normal   = (CNT_W'(r_idx) + CNT_W'(1)) == r_count;
    assign out_load      = (r_state == ST_RESULT) && (!r_out_valid || m_axis_tready);

    // operand select for the shared unit
    always_comb begin
        vec = (r_state == ST_PLANE) ? r_rd_data.n : r_q;
        mac_ctrl.acc_clr = (r_phase == PH_X);
        mac_ctrl.acc_add = (r_phase == PH_Y) || (r_phase == PH_Z) || (r_phase == PH_SCALE);
        opa = '0;
        opb = '0;
        case (r_phase)
            PH_X: begin
                opa = MA_W'(vec.x);
                opb = MB_W'(r_q.x);
            end
            PH_Y: begin
                opa = MA_W'(vec.y);
                opb = MB_W'(r_q.y);
            end
            PH_Z: begin
                opa = MA_W'(vec.z);
                opb = MB_W'(r_q.z);
            end
            PH_SCALE: begin
                if (r_state == ST_PLANE) begin
                    opa = MA_W'(r_rd_data.len_sq);
                    opb = MB_W'(half_eps);
                end else begin
                    opa = MA_W'(r_r2);
                    opb = MB_W'(one_eps);
                end
            end
            default: begin
                opa = '0;
                opb = '0;
            end
        endcase
    end

    pizhst_mac u_mac (
        .i_clk  (i_clk),
        .i_ctrl (mac_ctrl),
        .i_opa  (opa),
        .i_opb  (opb),
        .o_len  (mac_len),
        .o_gt   (mac_gt)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_idx   = r_idx;
        n_count = r_count;
        n_ovf   = r_ovf;
        n_cause = r_cause;
        mem_we  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                n_phase = PH_X;
                if (accept) begin
                    case (req)
                        REQ_CLEAR: begin
                            n_count = '0;
                            n_ovf   = 1'b0;
                        end
                        REQ_LOAD: begin
                            if (r_count == CNT_W'(MAX_NORMALS)) begin
                                n_ovf = 1'b1;
                            end else begin
                                n_state = ST_LOAD;
                            end
                        end
                        REQ_QUERY: begin
                            n_state = ST_SPHERE;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_LOAD: begin
                if (r_phase == PH_CMP) begin
                    mem_we  = 1'b1;
                    n_count = r_count + CNT_W'(1);
                    n_state = ST_IDLE;
                end else begin
                    n_phase = r_phase + PH_W'(1);
                end
            end
            ST_SPHERE: begin
                if (r_phase == PH_CMP) begin
                    n_phase = PH_X;
                    n_idx   = '0;
                    if (mac_gt) begin
                        n_cause = CAUSE_SPHERE;
                        n_state = ST_RESULT;
                    end else if (r_count == '0) begin
                        n_cause = CAUSE_NONE;
                        n_state = ST_RESULT;
                    end else begin
                        n_state = ST_PLANE;
                    end
                end else begin
                    n_phase = r_phase + PH_W'(1);
                end
            end
            ST_PLANE: begin
                if (r_phase == PH_CMP) begin
                    n_phase = PH_X;
                    if (mac_gt) begin
                        n_cause = CAUSE_PLANE;
                        n_state = ST_RESULT;
                    end else if (last_normal) begin
                        n_cause = CAUSE_NONE;
                        n_state = ST_RESULT;
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end else begin
                    n_phase = r_phase + PH_W'(1);
                end
            end
            ST_RESULT: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= PH_X;
            r_idx       <= '0;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_cause     <= CAUSE_NONE;
            r_r2        <= R2_RESET;
            r_tol       <= TOL_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_count <= n_count;
            r_ovf   <= n_ovf;
            r_cause <= n_cause;
            if (i_cfg_we && (i_cfg_idx == REG_SPHERE_R2)) begin
                r_r2 <= i_cfg_wdata[R2_W-1:0];
            end
            if (i_cfg_we && (i_cfg_idx == REG_TOLERANCE)) begin
                r_tol <= i_cfg_wdata[TOL_W-1:0];
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q <= s_axis_tdata[3*COORD_BITS-1:0];
        end
        if (out_load) begin
            r_out_data <= TDATA_OUT_W'({r_ovf, r_cause, (r_cause == CAUSE_NONE)});
        end
    end

    // normal table: written at the fill count, read one entry ahead
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_count[IDX_W-1:0]] <= '{len_sq: mac_len, n: r_q};
        end
        r_rd_data <= mem[n_idx];
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // a response is produced only out of the result state
    a_out_from_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_RESULT))
        else $error("response raised outside the result state");

    // the table never holds more than its capacity
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_NORMALS))
        else $error("normal count beyond capacity");

    // overflow is only flagged with a full table
    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_count == CNT_W'(MAX_NORMALS)))
        else $error("overflow flag set with room in the table");

    // the plane scan only visits stored entries
    a_plane_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PLANE) |-> (CNT_W'(r_idx) < r_count))
        else $error("plane scan index past the fill count");

    // the step counter stays within one pass
    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase <= PH_CMP)
        else $error("step counter out of range");

endmodule

`default_nettype wire

>>> sim/tb.sv
// Self-checking bench for point_in_zone_halfspace_test_top: streams clear, load
// and query requests and compares each zone verdict against a built-in predictor.
// Depends on pizhst_pkg and the block's RTL only.

module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pizhst_pkg::*;

    localparam int CYCLE_LIMIT   = 1_500_000;
    localparam int SETTLE_CYCLES = 200;   // longer than a full 32-normal query pass
    localparam int HOLD_CYCLES   = 600;
    localparam int MAX_REPORTS   = 10;
    localparam int COORD_MIN     = -(1 << (COORD_BITS - 1));
    localparam int COORD_MAX     = (1 << (COORD_BITS - 1)) - 1;

    typedef struct {
        t_req kind;
        t_vec v;
    } t_request;

    typedef struct packed {
        logic   in_zone;
        t_cause cause;
        logic   ovf;
    } t_verdict;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [TDATA_IN_W-1:0] s_axis_tdata = '0;   // coord_x, coord_y, coord_z, pad
    logic [TUSER_IN_W-1:0] s_axis_tuser = '0;   // req_type
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [TDATA_OUT_W-1:0] m_axis_tdata;       // is_inside, reject_cause, table_overflow, pad

    point_in_zone_halfspace_test_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // zone predictor state
    t_vec              zone_nrm [MAX_NORMALS];
    longint unsigned   zone_len [MAX_NORMALS];
    int                zone_cnt = 0;
    bit                zone_ovf = 1'b0;
    logic [R2_W-1:0]   zone_r2  = R2_RESET;
    logic [TOL_W-1:0]  zone_tol = TOL_RESET;

    t_request request_q [$];
    t_verdict verdict_q [$];
    t_request tx_cur;

    int phase_items = 0;
    int burst_left  = 0;
    int gap_left    = 0;
    int hold_req    = 0;
    int hold_seen   = 0;
    int hold_left   = 0;
    int rx_mode     = 0;
    int rx_mode_left = 0;
    int rx_tick     = 0;
    int cycle_cnt   = 0;
    int err_cnt     = 0;
    int n_loads = 0, n_clears = 0;
    int n_inside = 0, n_sphere = 0, n_plane = 0, n_ovf_seen = 0;

    function automatic longint unsigned len_sq(input t_vec v);
        longint sx, sy, sz;
        sx = v.x;
        sy = v.y;
        sz = v.z;
        return sx * sx + sy * sy + sz * sz;
    endfunction

    function automatic longint unsigned abs_dot(input t_vec a, input t_vec b);
        longint ax, ay, az, bx, by, bz, d;
        ax = a.x; ay = a.y; az = a.z;
        bx = b.x; by = b.y; bz = b.z;
        d = ax * bx + ay * by + az * bz;
        return (d < 0) ? -d : d;
    endfunction

    // lhs / rhs > k / 1.0, cross-multiplied
    function automatic bit exceeds(input longint unsigned lhs, input longint unsigned rhs,
                                   input longint unsigned k);
        return (lhs * SCALE_ONE) > (rhs * k);
    endfunction

    task automatic apply_request(input t_request r);
        t_verdict        vd;
        longint unsigned one_eps, half_eps;
        int              k;
        case (r.kind)
            REQ_CLEAR: begin
                zone_cnt = 0;
                zone_ovf = 1'b0;
                n_clears++;
            end
            REQ_LOAD: begin
                if (zone_cnt < MAX_NORMALS) begin
                    zone_nrm[zone_cnt] = r.v;
                    zone_len[zone_cnt] = len_sq(r.v);
                    zone_cnt++;
                end else begin
                    zone_ovf = 1'b1;
                end
                n_loads++;
            end
            REQ_QUERY: begin
                one_eps  = SCALE_ONE + zone_tol;
                half_eps = SCALE_HALF + zone_tol;
                vd.cause = CAUSE_NONE;
                // sphere goes first, then the planes in load order
                if (exceeds(len_sq(r.v), zone_r2, one_eps)) begin
                    vd.cause = CAUSE_SPHERE;
                end else begin
                    for (k = 0; k < zone_cnt; k++) begin
                        if (vd.cause == CAUSE_NONE &&
                            exceeds(abs_dot(zone_nrm[k], r.v), zone_len[k], half_eps))
                            vd.cause = CAUSE_PLANE;
                    end
                end
                vd.in_zone = (vd.cause == CAUSE_NONE);
                vd.ovf     = zone_ovf;
                verdict_q.push_back(vd);
            end
            default: ;
        endcase
    endtask

    function automatic t_vec mk_vec(input int x, input int y, input int z);
        t_vec v;
        v.x = COORD_BITS'(x);
        v.y = COORD_BITS'(y);
        v.z = COORD_BITS'(z);
        return v;
    endfunction

    function automatic int clip(input int c);
        if (c < COORD_MIN) return COORD_MIN;
        if (c > COORD_MAX) return COORD_MAX;
        return c;
    endfunction

    function automatic int rnd_comp(input int span);
        if (span > COORD_MAX)
            return int'($urandom_range(0, 2 * COORD_MAX + 1)) + COORD_MIN;
        if ($urandom_range(0, 5) == 0)
            return 0;
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    // near the mid-plane of a normal: +-n/2 with a little jitter
    function automatic int near_half(input int c, input int sgn);
        return clip(sgn * (c >>> 1) + int'($urandom_range(0, 4)) - 2);
    endfunction

    task automatic push_req(input t_req kind, input t_vec v);
        t_request r;
        r.kind = kind;
        r.v    = v;
        request_q.push_back(r);
        if (kind != REQ_NONE)
            phase_items++;
    endtask

    task automatic gen_sequence();
        t_vec nrm [$];
        t_vec nv, qv;
        int   span, n_ld, n_qry, j, pick, sgn;
        // stray request, any code including the unused one
        if ($urandom_range(0, 11) == 0) begin
            push_req(t_req'($urandom_range(0, 3)),
                     mk_vec(rnd_comp(COORD_MAX + 1), rnd_comp(COORD_MAX + 1),
                            rnd_comp(COORD_MAX + 1)));
            return;
        end
        case ($urandom_range(0, 9))
            0, 1, 2, 3: span = $urandom_range(16, 2048);
            4, 5, 6, 7: span = $urandom_range(2048, 16384);
            8:          span = COORD_MAX + 1;
            default:    span = $urandom_range(1, 8);
        endcase
        // now and then skip the clear so the table keeps growing
        if ($urandom_range(0, 7) != 0)
            push_req(REQ_CLEAR, mk_vec(rnd_comp(span), rnd_comp(span), rnd_comp(span)));
        case ($urandom_range(0, 9))
            0:       n_ld = 0;
            1:       n_ld = $urandom_range(MAX_NORMALS - 2, MAX_NORMALS + 4);
            default: n_ld = $urandom_range(1, 6);
        endcase
        for (j = 0; j < n_ld; j++) begin
            nv = mk_vec(rnd_comp(span), rnd_comp(span), rnd_comp(span));
            nrm.push_back(nv);
            push_req(REQ_LOAD, nv);
        end
        n_qry = $urandom_range(1, 6);
        for (j = 0; j < n_qry; j++) begin
            pick = $urandom_range(0, 9);
            if (pick < 4 && nrm.size() > 0) begin
                nv  = nrm[$urandom_range(0, nrm.size() - 1)];
                sgn = ($urandom_range(0, 1) != 0) ? 1 : -1;
                qv  = mk_vec(near_half(nv.x, sgn), near_half(nv.y, sgn), near_half(nv.z, sgn));
            end else if (pick < 9) begin
                qv = mk_vec(rnd_comp(span), rnd_comp(span), rnd_comp(span));
            end else begin
                qv = mk_vec(rnd_comp(COORD_MAX + 1), rnd_comp(COORD_MAX + 1),
                            rnd_comp(COORD_MAX + 1));
            end
            push_req(REQ_QUERY, qv);
        end
    endtask

    task automatic wait_idle();
        while (request_q.size() != 0 || s_axis_tvalid || verdict_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_zone_cfg(input logic [R2_W-1:0] r2, input logic [TOL_W-1:0] tol);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= REG_SPHERE_R2;
        i_cfg_wdata <= CFG_DATA_W'(r2);
        zone_r2 = r2;
        @(posedge i_clk);
        i_cfg_idx   <= REG_TOLERANCE;
        i_cfg_wdata <= CFG_DATA_W'(tol);
        zone_tol = tol;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic run_random(input logic [R2_W-1:0] r2, input logic [TOL_W-1:0] tol,
                              input int target, input bit with_hold);
        wait_idle();
        set_zone_cfg(r2, tol);
        @(negedge i_clk);
        phase_items = 0;
        while (phase_items < target)
            gen_sequence();
        if (with_hold)
            hold_req++;
    endtask

    // request driver: bursts with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                apply_request(tx_cur);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (request_q.size() > 0) begin
                    tx_cur = request_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= TDATA_IN_W'(tx_cur.v);
                    s_axis_tuser  <= tx_cur.kind;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 16);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // response ready: own stall pattern plus an occasional long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            rx_tick++;
            if (hold_seen != hold_req) begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (rx_mode_left == 0) begin
                rx_mode      = $urandom_range(0, 3);
                rx_mode_left = $urandom_range(32, 256);
            end else begin
                rx_mode_left--;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                case (rx_mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= ($urandom_range(0, 1) != 0);
                    2:       m_axis_tready <= ((rx_tick % 4) != 0);
                    default: m_axis_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // response checker
    always @(posedge i_clk) begin
        t_verdict want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (verdict_q.size() == 0) begin
                err_cnt++;
                if (err_cnt <= MAX_REPORTS)
                    $display("unexpected response 0x%02h at cycle %0d",
                             m_axis_tdata, cycle_cnt);
            end else begin
                want = verdict_q.pop_front();
                if (want.in_zone) n_inside++;
                if (want.cause == CAUSE_SPHERE) n_sphere++;
                if (want.cause == CAUSE_PLANE) n_plane++;
                if (want.ovf) n_ovf_seen++;
                if (m_axis_tdata[0] !== want.in_zone || m_axis_tdata[2:1] !== want.cause ||
                    m_axis_tdata[3] !== want.ovf) begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORTS)
                        $display({"mismatch at cycle %0d: expected in_zone=%0b cause=%0d ",
                                  "ovf=%0b, got in_zone=%0b cause=%0d ovf=%0b"},
                                 cycle_cnt, want.in_zone, want.cause, want.ovf,
                                 m_axis_tdata[0], m_axis_tdata[2:1], m_axis_tdata[3]);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d responses outstanding",
                     cycle_cnt, verdict_q.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults: empty table, extremes, exact plane boundary, zero normal
        @(negedge i_clk);
        push_req(REQ_QUERY, mk_vec(0, 0, 0));
        push_req(REQ_QUERY, mk_vec(COORD_MIN, COORD_MIN, COORD_MIN));
        push_req(REQ_QUERY, mk_vec(COORD_MAX, COORD_MAX, COORD_MAX));
        push_req(REQ_NONE,  mk_vec(-1, -1, -1));
        push_req(REQ_LOAD,  mk_vec(4096, 0, 0));
        push_req(REQ_LOAD,  mk_vec(0, 4096, 0));
        push_req(REQ_LOAD,  mk_vec(0, 0, 4096));
        push_req(REQ_LOAD,  mk_vec(0, 0, 0));
        push_req(REQ_QUERY, mk_vec(2048, -2048, 2048));
        push_req(REQ_QUERY, mk_vec(2049, 0, 0));
        push_req(REQ_QUERY, mk_vec(0, 0, -2049));
        push_req(REQ_LOAD,  mk_vec(COORD_MIN, COORD_MAX, COORD_MIN));
        push_req(REQ_QUERY, mk_vec(COORD_MAX, COORD_MAX, COORD_MAX));
        push_req(REQ_CLEAR, mk_vec(0, 0, 0));
        push_req(REQ_QUERY, mk_vec(COORD_MAX, 0, 0));
        wait_idle();

        // sphere of radius 1.0 with no slack; sphere and plane both failing
        set_zone_cfg(R2_W'(1) << 24, '0);
        @(negedge i_clk);
        push_req(REQ_QUERY, mk_vec(4096, 0, 0));
        push_req(REQ_QUERY, mk_vec(4097, 0, 0));
        push_req(REQ_LOAD,  mk_vec(4096, 0, 0));
        push_req(REQ_QUERY, mk_vec(COORD_MAX, 0, 0));
        push_req(REQ_QUERY, mk_vec(0, 0, 0));
        wait_idle();

        // widest tolerance moves the plane out to about 1.5 |n|
        set_zone_cfg(R2_RESET, '1);
        @(negedge i_clk);
        push_req(REQ_QUERY, mk_vec(6143, 0, 0));
        push_req(REQ_QUERY, mk_vec(6144, 0, 0));

        run_random('0, '0, 150, 1'b0);
        run_random(R2_W'(1) << 26, TOL_W'(7), 350, 1'b1);
        run_random(R2_W'({$urandom_range(0, 15), $urandom}), TOL_W'($urandom_range(0, 65535)),
                   350, 1'b0);
        run_random(R2_W'($urandom_range(1 << 20, 1 << 31)), TOL_W'($urandom_range(0, 400)),
                   400, 1'b0);
        run_random(R2_RESET, '1, 350, 1'b0);
        run_random(R2_W'(1) << 28, '0, 400, 1'b0);
        wait_idle();

        $display({"Checked %0d query responses: %0d inside, %0d sphere rejects, ",
                  "%0d plane rejects, %0d with overflow set"},
                 n_inside + n_sphere + n_plane, n_inside, n_sphere, n_plane, n_ovf_seen);
        $display({"Applied %0d normal loads and %0d clears under 9 register settings, ",
                  "with a %0d-cycle output hold-off"},
                 n_loads, n_clears, HOLD_CYCLES);
        if (err_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> filelist.f
sv/pizhst_pkg.sv
sv/pizhst_mac.sv
sv/point_in_zone_halfspace_test_top.sv
sim/tb.sv
